[rtl/lbga_pkg.sv]
package lbga_pkg;

  localparam int MAX_SEGMENTS   = 32;
  localparam int SEG_CAP        = (MAX_SEGMENTS < 32) ? MAX_SEGMENTS : 32;
  localparam int WIDE_BAR_LIMIT = 16;
  localparam int SEG_W          = 32;
  localparam int CNT_W          = 6;
  localparam int PERIOD_W       = 8;
  localparam int CFG_ADDR_W     = 3;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_BOOT     = 3'd1,
    OP_SWEEP    = 3'd2,
    OP_BOUNCE   = 3'd3,
    OP_FIRING   = 3'd4,
    OP_SHUTDOWN = 3'd5,
    OP_ALL_ON   = 3'd6,
    OP_ALL_OFF  = 3'd7
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_SEGMENTS    = 3'd0,
    REG_BOOT_PERIOD     = 3'd1,
    REG_SWEEP_PERIOD    = 3'd2,
    REG_BOUNCE_PERIOD   = 3'd3,
    REG_FIRING_PERIOD   = 3'd4,
    REG_SHUTDOWN_PERIOD = 3'd5,
    REG_SPARE6          = 3'd6,
    REG_SPARE7          = 3'd7
  } reg_e;

  function automatic logic [SEG_W-1:0] seg_mask(input logic [CNT_W-1:0] n);
    if (n >= 6'd32) begin
      return '1;
    end
    return (32'd1 << n) - 32'd1;
  endfunction

  // bits at index k and above, k may lie outside 0..n
  function automatic logic [SEG_W-1:0] from_bit(input logic signed [7:0] k,
                                                input logic [CNT_W-1:0] n);
    if (k <= 8'sd0) begin
      return seg_mask(n);
    end
    if (k >= $signed({2'b00, n})) begin
      return '0;
    end
    return seg_mask(n) & ~seg_mask(k[CNT_W-1:0]);
  endfunction

  function automatic logic [SEG_W-1:0] below_bit(input logic signed [7:0] k,
                                                 input logic [CNT_W-1:0] n);
    return seg_mask(n) & ~from_bit(k, n);
  endfunction

  function automatic logic [SEG_W-1:0] one_bit(input logic signed [7:0] k,
                                               input logic [CNT_W-1:0] n);
    if (k < 8'sd0 || k >= $signed({2'b00, n})) begin
      return '0;
    end
    return 32'd1 << k[4:0];
  endfunction

endpackage

[rtl/led_bar_graph_animator_core.sv]
// A request's result enters the result register when the request leaves the input register.
// Throughput: one request per cycle unless the output stalls; the animation state
//   updates in the same cycle the request moves from the input to the result register.
// An input register and a result register decouple the two stream sides.
// Reset (rst_ni low, asynchronous) clears all animation state and loads the
//   default segment count and step periods.
module led_bar_graph_animator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbga_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [lbga_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,  // now_ms
  input  logic [3:0]                     s_axis_tuser_i,  // operation[2:0], restart
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [39:0]                    m_axis_tdata_o   // segment_bits[31:0], powered, pad
);
  import lbga_pkg::*;

  logic [CNT_W-1:0]    num_seg_q;
  logic [PERIOD_W-1:0] boot_per_q, sweep_per_q, bounce_per_q, firing_per_q, shut_per_q;

  logic                in_valid_q;
  op_e                 in_op_q;
  logic                in_restart_q;
  logic [31:0]         in_now_q;

  logic                out_valid_q;
  logic [SEG_W-1:0]    out_seg_q;
  logic                out_pwr_q;

  logic [SEG_W-1:0]    lit_q, lit_d;
  logic signed [6:0]   run_q, run_d;
  logic [4:0]          fire_q, fire_d;
  logic                back_q, back_d;
  logic                booted_q, booted_d;
  logic                boot_ph2_q, boot_ph2_d;
  logic                shut_ph2_q, shut_ph2_d;
  logic [31:0]         last_q, last_d;

  logic                advance;
  logic                accept;
  logic [CNT_W-1:0]    n;
  logic signed [7:0]   ns;
  logic [SEG_W-1:0]    mask_n;
  logic [31:0]         elapsed;
  logic [PERIOD_W-1:0] period;
  logic                is_due;
  logic                booted_eff;
  logic [SEG_W-1:0]    seg_out;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (num_seg_q < 6'd2) begin
      n = 6'd2;
    end else if (num_seg_q > CNT_W'(SEG_CAP)) begin
      n = CNT_W'(SEG_CAP);
    end else begin
      n = num_seg_q;
    end
  end

  assign ns     = $signed({2'b00, n});
  assign mask_n = seg_mask(n);

  always_comb begin
    booted_eff = booted_q;
    if (in_restart_q && in_op_q == OP_BOOT) begin
      booted_eff = 1'b0;
    end else if (in_restart_q && in_op_q == OP_SHUTDOWN) begin
      booted_eff = 1'b1;
    end
  end

  always_comb begin
    unique case (in_op_q)
      OP_BOOT:     period = booted_eff ? sweep_per_q : boot_per_q;
      OP_SWEEP:    period = sweep_per_q;
      OP_BOUNCE:   period = bounce_per_q;
      OP_FIRING:   period = firing_per_q;
      OP_SHUTDOWN: period = shut_per_q;
      default:     period = '0;
    endcase
  end

  assign elapsed = in_now_q - last_q;
  assign is_due  = elapsed >= {24'd0, period};

  always_comb begin
    logic [SEG_W-1:0]  lit;
    logic [SEG_W-1:0]  b;
    logic signed [7:0] rp;
    logic signed [7:0] f;
    logic signed [7:0] top;
    logic              gb, bt, bp2, sp2, step, put, sweep;

    lit  = lit_q;
    b    = '0;
    rp   = 8'(run_q);
    f    = {3'b000, fire_q};
    top  = $signed({3'b000, n[CNT_W-1:1]}) - 8'sd1;
    gb   = back_q;
    bt   = booted_q;
    bp2  = boot_ph2_q;
    sp2  = shut_ph2_q;
    step = 1'b0;
    put  = 1'b0;
    sweep = 1'b0;

    unique case (in_op_q)
      OP_CLEAR: begin
        gb = 1'b0; rp = '0; f = '0; bt = 1'b0; put = 1'b1;
      end
      OP_BOOT: begin
        if (in_restart_q) begin
          rp = ns; bt = 1'b0; bp2 = 1'b0;
        end
        if (bt) begin
          sweep = 1'b1;
        end else if (is_due) begin
          step = 1'b1; put = 1'b1;
          if (!bp2) begin
            b = from_bit(rp, n);
            if (rp >= 8'sd0) rp = rp - 8'sd1;
            if (rp < 8'sd0) begin
              bp2 = 1'b1; rp = ns;
            end
          end else begin
            b = below_bit(rp, n);
            if (rp >= 8'sd0) rp = rp - 8'sd1;
            if (rp < 8'sd0) begin
              bt = 1'b1; rp = '0;
            end
          end
        end
      end
      OP_SWEEP: begin
        sweep = 1'b1;
      end
      OP_BOUNCE: begin
        if (is_due) begin
          step = 1'b1; put = 1'b1;
          b = one_bit(rp - 8'sd1, n);
          if (!gb) begin
            rp = rp + 8'sd1;
            if (rp >= ns) begin
              rp = ns; gb = 1'b1;
            end
          end else begin
            rp = rp - 8'sd1;
            if (rp <= 8'sd1) begin
              rp = 8'sd1; gb = 1'b0;
            end
          end
        end
      end
      OP_FIRING: begin
        if (is_due) begin
          step = 1'b1; put = 1'b1;
          b = one_bit(f, n) | one_bit(ns - 8'sd1 - f, n);
          if (n > CNT_W'(WIDE_BAR_LIMIT)) begin
            b = b | one_bit(f + 8'sd1, n) | one_bit(ns - f, n);
          end
          if (!gb) begin
            f = f + 8'sd1;
            if (f >= top) begin
              f = top; gb = 1'b1;
            end
          end else begin
            if (f > 8'sd0) f = f - 8'sd1;
            if (f <= 8'sd0) gb = 1'b0;
          end
        end
      end
      OP_SHUTDOWN: begin
        if (in_restart_q) begin
          rp = '0; bt = 1'b1; sp2 = 1'b0;
        end
        if (!bt) begin
          gb = 1'b0; rp = '0; f = '0; put = 1'b1;
        end else if (is_due) begin
          step = 1'b1; put = 1'b1;
          if (!sp2) begin
            b = below_bit(rp, n);
            if (rp < ns) rp = rp + 8'sd1;
            if (rp >= ns) begin
              sp2 = 1'b1; rp = '0;
            end
          end else begin
            b = from_bit(rp, n);
            if (rp < ns) rp = rp + 8'sd1;
            if (rp >= ns) begin
              bt = 1'b0; rp = '0;
            end
          end
        end
      end
      OP_ALL_ON: begin
        b = '1; put = 1'b1;
      end
      default: begin
        put = 1'b1;
      end
    endcase

    if (sweep && is_due) begin
      step = 1'b1; put = 1'b1;
      b = (rp <= 8'sd0) ? '0 : below_bit(rp, n);
      if (!gb) begin
        rp = rp + 8'sd1;
        if (rp > ns) begin
          rp = ns; gb = 1'b1;
        end
      end else begin
        if (rp > 8'sd0) rp = rp - 8'sd1;
        if (rp == 8'sd0) gb = 1'b0;
      end
    end

    if (put) begin
      lit = (lit & ~mask_n) | (b & mask_n);
    end

    lit_d      = lit;
    run_d      = rp[6:0];
    fire_d     = f[4:0];
    back_d     = gb;
    booted_d   = bt;
    boot_ph2_d = bp2;
    shut_ph2_d = sp2;
    last_d     = step ? in_now_q : last_q;
    seg_out    = lit & mask_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seg_q    <= 6'd28;
      boot_per_q   <= 8'd20;
      sweep_per_q  <= 8'd30;
      bounce_per_q <= 8'd30;
      firing_per_q <= 8'd20;
      shut_per_q   <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_NUM_SEGMENTS:    num_seg_q    <= cfg_wdata_i[CNT_W-1:0];
        REG_BOOT_PERIOD:     boot_per_q   <= cfg_wdata_i;
        REG_SWEEP_PERIOD:    sweep_per_q  <= cfg_wdata_i;
        REG_BOUNCE_PERIOD:   bounce_per_q <= cfg_wdata_i;
        REG_FIRING_PERIOD:   firing_per_q <= cfg_wdata_i;
        REG_SHUTDOWN_PERIOD: shut_per_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q      <= '0;
      run_q      <= '0;
      fire_q     <= '0;
      back_q     <= 1'b0;
      booted_q   <= 1'b0;
      boot_ph2_q <= 1'b0;
      shut_ph2_q <= 1'b0;
      last_q     <= '0;
    end else if (advance) begin
      lit_q      <= lit_d;
      run_q      <= run_d;
      fire_q     <= fire_d;
      back_q     <= back_d;
      booted_q   <= booted_d;
      boot_ph2_q <= boot_ph2_d;
      shut_ph2_q <= shut_ph2_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q      <= op_e'(s_axis_tuser_i[2:0]);
      in_restart_q <= s_axis_tuser_i[3];
      in_now_q     <= s_axis_tdata_i;
    end
    if (advance) begin
      out_seg_q <= seg_out;
      out_pwr_q <= booted_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_pwr_q, out_seg_q};

`ifndef SYNTH
  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled after advance");

  a_fire_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q < 5'd16)
    else $error("fire position out of range");

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q >= 7'sd0) && (run_q <= 7'sd32))
    else $error("run position out of range");
`endif

endmodule
